>>> sv/pidc_pkg.sv
// Shared widths, register codes, command types and reset values for the speed PID controller.
package pidc_pkg;

  localparam int SPEED_W    = 16;
  localparam int ERR_W      = SPEED_W + 1;
  localparam int DT_W       = 32;
  localparam int GAIN_W     = 20;
  localparam int THR_W      = 24;
  localparam int INTEG_W    = 56;
  localparam int INTEG_SH   = 16;
  localparam int INTEG_Q_W  = INTEG_W - INTEG_SH;
  localparam int GAIN_SH    = 12;
  localparam int SPLIT      = 20;
  localparam int MUL_A_W    = GAIN_W;
  localparam int MUL_B_W    = SPLIT + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int TERM_W     = PROD_W + SPLIT;
  localparam int SUM_W      = TERM_W - GAIN_SH;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int DIV_W      = ERR_W + 16;
  localparam int DERIV_W    = DIV_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = THR_W;

  localparam logic signed [GAIN_W-1:0]  PROP_GAIN_RST  = GAIN_W'(2048);
  localparam logic signed [GAIN_W-1:0]  INTEG_GAIN_RST = GAIN_W'(410);
  localparam logic signed [GAIN_W-1:0]  DERIV_GAIN_RST = GAIN_W'(410);
  localparam logic signed [THR_W-1:0]   THR_FLOOR_RST  = THR_W'(0);
  localparam logic signed [THR_W-1:0]   THR_CEIL_RST   = THR_W'(25600);
  localparam logic signed [SPEED_W-1:0] SPEED_CAP_RST  = SPEED_W'(2560);

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_DERIV_GAIN,
    CFG_THR_FLOOR,
    CFG_THR_CEIL,
    CFG_SPEED_CAP
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MUL_ERR_DTLO,
    MUL_ERR_DTHI,
    MUL_KP_ERR,
    MUL_KI_LO,
    MUL_KI_HI,
    MUL_KD_LO,
    MUL_KD_HI
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic signed [THR_W-1:0]   thr_floor;
    logic signed [THR_W-1:0]   thr_ceil;
    logic signed [SPEED_W-1:0] speed_cap;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     calc_err;
    logic     div_start;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     integ_upd;
    logic     sum_clr;
    logic     sum_add;
    logic     deriv_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

>>> sv/pidc_cfg.sv
// Configuration register file: gains, throttle limits and speed cap.
module pidc_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output pidc_pkg::cfg_t                       cfg
);

  pidc_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp        <= pidc_pkg::PROP_GAIN_RST;
      cfg_r.ki        <= pidc_pkg::INTEG_GAIN_RST;
      cfg_r.kd        <= pidc_pkg::DERIV_GAIN_RST;
      cfg_r.thr_floor <= pidc_pkg::THR_FLOOR_RST;
      cfg_r.thr_ceil  <= pidc_pkg::THR_CEIL_RST;
      cfg_r.speed_cap <= pidc_pkg::SPEED_CAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pidc_pkg::CFG_PROP_GAIN:  cfg_r.kp        <= cfg_data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::CFG_INTEG_GAIN: cfg_r.ki        <= cfg_data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::CFG_DERIV_GAIN: cfg_r.kd        <= cfg_data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::CFG_THR_FLOOR:  cfg_r.thr_floor <= cfg_data[pidc_pkg::THR_W-1:0];
        pidc_pkg::CFG_THR_CEIL:   cfg_r.thr_ceil  <= cfg_data[pidc_pkg::THR_W-1:0];
        pidc_pkg::CFG_SPEED_CAP:  cfg_r.speed_cap <= cfg_data[pidc_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/pidc_datapath.sv
// Datapath: error, timestamp delta, shared 20x21 multiplier, restoring divider, clamp.
module pidc_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pidc_pkg::cfg_t                        cfg,
  input  pidc_pkg::dp_cmd_t                     cmd,
  output pidc_pkg::dp_stat_t                    stat,
  input  logic [pidc_pkg::DT_W-1:0]             in_now_time,
  input  logic signed [pidc_pkg::SPEED_W-1:0]   in_target_speed,
  input  logic signed [pidc_pkg::SPEED_W-1:0]   in_measured_speed,
  output logic signed [pidc_pkg::THR_W-1:0]     out_throttle
);

  localparam int ERR_W   = pidc_pkg::ERR_W;
  localparam int DT_W    = pidc_pkg::DT_W;
  localparam int TERM_W  = pidc_pkg::TERM_W;
  localparam int PROD_W  = pidc_pkg::PROD_W;
  localparam int SUM_W   = pidc_pkg::SUM_W;
  localparam int INTEG_W = pidc_pkg::INTEG_W;
  localparam int DIV_W   = pidc_pkg::DIV_W;
  localparam int SPLIT   = pidc_pkg::SPLIT;
  localparam int THR_W   = pidc_pkg::THR_W;

  // Item state
  logic signed [pidc_pkg::SPEED_W-1:0] tgt_r, meas_r;
  logic [DT_W-1:0]                     dt_r;
  logic signed [ERR_W-1:0]             err_r;
  logic                                neg_r;
  logic signed [pidc_pkg::DERIV_W-1:0] deriv_r;
  // Loop state
  logic [DT_W-1:0]                     last_r;
  logic signed [ERR_W-1:0]             prev_r;
  logic signed [INTEG_W-1:0]           integ_r;
  // Arithmetic
  logic signed [PROD_W-1:0]            prod_r;
  logic signed [TERM_W-1:0]            term_r;
  logic signed [SUM_W-1:0]             sum_r;
  logic signed [THR_W-1:0]             out_r;
  // Divider
  logic [DT_W-1:0]                     rem_r;
  logic [DIV_W-1:0]                    dvd_r;
  logic [pidc_pkg::DIV_CNT_W-1:0]      div_cnt_r;

  logic signed [pidc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pidc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pidc_pkg::INTEG_Q_W-1:0] integ_q;
  logic signed [pidc_pkg::DIFF_W-1:0]  diff;
  logic [pidc_pkg::DIFF_W-1:0]         mag;
  logic signed [TERM_W-1:0]            prod_ext;
  logic signed [TERM_W-1:0]            integ_sum;
  logic signed [INTEG_W-1:0]           integ_nxt;
  logic [DIV_W-1:0]                    div_shift, div_sub;
  logic                                div_ge;
  logic signed [SUM_W-1:0]             floor_ext, ceil_ext, lo_clamp;
  logic signed [THR_W-1:0]             out_nxt;

  assign integ_q  = integ_r[INTEG_W-1:pidc_pkg::INTEG_SH];
  assign prod_ext = {{(TERM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    mul_a = cfg.kp;
    mul_b = '0;
    case (cmd.mul_sel)
      pidc_pkg::MUL_ERR_DTLO: begin
        mul_a = {{(pidc_pkg::MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {1'b0, dt_r[SPLIT-1:0]};
      end
      pidc_pkg::MUL_ERR_DTHI: begin
        mul_a = {{(pidc_pkg::MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {{(pidc_pkg::MUL_B_W-(DT_W-SPLIT)){1'b0}}, dt_r[DT_W-1:SPLIT]};
      end
      pidc_pkg::MUL_KP_ERR: begin
        mul_a = cfg.kp;
        mul_b = {{(pidc_pkg::MUL_B_W-ERR_W){err_r[ERR_W-1]}}, err_r};
      end
      pidc_pkg::MUL_KI_LO: begin
        mul_a = cfg.ki;
        mul_b = {1'b0, integ_q[SPLIT-1:0]};
      end
      pidc_pkg::MUL_KI_HI: begin
        mul_a = cfg.ki;
        mul_b = {{(pidc_pkg::MUL_B_W-(pidc_pkg::INTEG_Q_W-SPLIT)){integ_q[pidc_pkg::INTEG_Q_W-1]}},
                 integ_q[pidc_pkg::INTEG_Q_W-1:SPLIT]};
      end
      pidc_pkg::MUL_KD_LO: begin
        mul_a = cfg.kd;
        mul_b = {1'b0, deriv_r[SPLIT-1:0]};
      end
      pidc_pkg::MUL_KD_HI: begin
        mul_a = cfg.kd;
        mul_b = {{(pidc_pkg::MUL_B_W-(pidc_pkg::DERIV_W-SPLIT)){deriv_r[pidc_pkg::DERIV_W-1]}},
                 deriv_r[pidc_pkg::DERIV_W-1:SPLIT]};
      end
      default: ;
    endcase
  end

  // Error change against the previous item, magnitude scaled by 2^16 for the divide
  always_comb begin
    diff = {err_r[ERR_W-1], err_r} - {prev_r[ERR_W-1], prev_r};
    mag  = diff[pidc_pkg::DIFF_W-1] ? pidc_pkg::DIFF_W'(-diff) : diff;
  end

  // Saturate the integral to its signed range
  always_comb begin
    integ_sum = {{(TERM_W-INTEG_W){integ_r[INTEG_W-1]}}, integ_r} + term_r;
    if (integ_sum[TERM_W-1:INTEG_W-1] == {(TERM_W-INTEG_W+1){integ_sum[TERM_W-1]}}) begin
      integ_nxt = integ_sum[INTEG_W-1:0];
    end else if (integ_sum[TERM_W-1]) begin
      integ_nxt = pidc_pkg::INTEG_MIN;
    end else begin
      integ_nxt = pidc_pkg::INTEG_MAX;
    end
  end

  // One quotient bit per cycle
  always_comb begin
    div_shift = {rem_r, dvd_r[DIV_W-1]};
    div_sub   = div_shift - {1'b0, dt_r};
    div_ge    = (div_shift >= {1'b0, dt_r});
  end

  // Floor first, then ceiling wins
  always_comb begin
    floor_ext = {{(SUM_W-THR_W){cfg.thr_floor[THR_W-1]}}, cfg.thr_floor};
    ceil_ext  = {{(SUM_W-THR_W){cfg.thr_ceil[THR_W-1]}}, cfg.thr_ceil};
    lo_clamp  = (sum_r < floor_ext) ? floor_ext : sum_r;
    out_nxt   = (lo_clamp > ceil_ext) ? cfg.thr_ceil : lo_clamp[THR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      prev_r    <= '0;
      integ_r   <= '0;
      div_cnt_r <= '0;
    end else begin
      if (cmd.capture) begin
        last_r <= in_now_time;
      end
      if (cmd.integ_upd) begin
        integ_r <= integ_nxt;
      end
      if (cmd.out_load) begin
        prev_r <= err_r;
      end
      if (cmd.div_start) begin
        div_cnt_r <= pidc_pkg::DIV_CNT_W'(DIV_W);
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tgt_r  <= (in_target_speed > cfg.speed_cap) ? cfg.speed_cap : in_target_speed;
      meas_r <= in_measured_speed;
      dt_r   <= in_now_time - last_r;
    end
    if (cmd.calc_err) begin
      err_r <= {tgt_r[pidc_pkg::SPEED_W-1], tgt_r} - {meas_r[pidc_pkg::SPEED_W-1], meas_r};
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      dvd_r <= {mag[ERR_W-1:0], 16'b0};
      neg_r <= diff[pidc_pkg::DIFF_W-1];
    end else if (div_cnt_r != '0) begin
      rem_r <= div_ge ? div_sub[DT_W-1:0] : div_shift[DT_W-1:0];
      dvd_r <= {dvd_r[DIV_W-2:0], div_ge};
    end
    if (cmd.deriv_load) begin
      if (dt_r == '0) begin
        deriv_r <= '0;
      end else if (neg_r) begin
        deriv_r <= -$signed({1'b0, dvd_r});
      end else begin
        deriv_r <= $signed({1'b0, dvd_r});
      end
    end
    prod_r <= mul_a * mul_b;
    case (cmd.acc_op)
      pidc_pkg::ACC_LOAD:   term_r <= prod_ext;
      pidc_pkg::ACC_ADD_HI: term_r <= term_r + (prod_ext <<< SPLIT);
      default: ;
    endcase
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + term_r[SUM_W+pidc_pkg::GAIN_SH-1:pidc_pkg::GAIN_SH];
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign stat.div_done = (div_cnt_r == '0);
  assign out_throttle  = out_r;

endmodule

>>> sv/pidc_ctrl.sv
// Controller: sequences capture, multiplies, divide and result hand-off.
module pidc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_flags_ok,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pidc_pkg::dp_stat_t  stat,
  output pidc_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_DIFF, S_M1, S_M2, S_INTEG, S_M3, S_M4,
    S_M5, S_M6, S_DWAIT, S_M7, S_M8, S_M9, S_M10, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = pidc_pkg::MUL_ERR_DTLO;
    cmd.acc_op    = pidc_pkg::ACC_HOLD;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        // drop transactions with a flag clear
        if (in_valid && in_flags_ok) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ERR;
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        state_nxt    = S_DIFF;
      end
      S_DIFF: begin
        cmd.div_start = 1'b1;
        cmd.mul_sel   = pidc_pkg::MUL_ERR_DTLO;
        state_nxt     = S_M1;
      end
      S_M1: begin
        cmd.mul_sel = pidc_pkg::MUL_ERR_DTHI;
        cmd.acc_op  = pidc_pkg::ACC_LOAD;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.acc_op = pidc_pkg::ACC_ADD_HI;
        state_nxt  = S_INTEG;
      end
      S_INTEG: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_sel   = pidc_pkg::MUL_KP_ERR;
        state_nxt     = S_M3;
      end
      S_M3: begin
        cmd.acc_op  = pidc_pkg::ACC_LOAD;
        cmd.mul_sel = pidc_pkg::MUL_KI_LO;
        cmd.sum_clr = 1'b1;
        state_nxt   = S_M4;
      end
      S_M4: begin
        cmd.sum_add = 1'b1;
        cmd.mul_sel = pidc_pkg::MUL_KI_HI;
        cmd.acc_op  = pidc_pkg::ACC_LOAD;
        state_nxt   = S_M5;
      end
      S_M5: begin
        cmd.acc_op = pidc_pkg::ACC_ADD_HI;
        state_nxt  = S_M6;
      end
      S_M6: begin
        cmd.sum_add = 1'b1;
        state_nxt   = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.deriv_load = 1'b1;
          state_nxt      = S_M7;
        end
      end
      S_M7: begin
        cmd.mul_sel = pidc_pkg::MUL_KD_LO;
        state_nxt   = S_M8;
      end
      S_M8: begin
        cmd.mul_sel = pidc_pkg::MUL_KD_HI;
        cmd.acc_op  = pidc_pkg::ACC_LOAD;
        state_nxt   = S_M9;
      end
      S_M9: begin
        cmd.acc_op = pidc_pkg::ACC_ADD_HI;
        state_nxt  = S_M10;
      end
      S_M10: begin
        cmd.sum_add = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // hold while the previous result is still stalled
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_capture_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_flags_ok) |=> state_r == S_ERR)
    else $error("valid transaction did not start processing");

  a_invalid_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && !in_flags_ok) |=> (state_r == S_IDLE && !$rose(out_valid_r)))
    else $error("transaction with a flag clear produced work");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_deriv_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deriv_load |-> stat.div_done)
    else $error("derivative taken before the divide finished");

endmodule

>>> sv/pid_speed_controller_core.sv
// Top level of the speed PID controller with clamped throttle output.
// An item is accepted only while idle; in_stall is high until its result is loaded.
// Most of the time goes to the 33-step restoring divider that forms the derivative.
// Items with vehicle_valid or path_valid clear are accepted while idle and dropped.
// Reset (rst_n low, synchronous) restores register defaults and clears the stored
// error, integral and timestamp; it takes effect at once, with no clearing pass.
module pid_speed_controller_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pidc_pkg::DT_W-1:0]            in_now_time,
  input  logic signed [pidc_pkg::SPEED_W-1:0]  in_target_speed,
  input  logic signed [pidc_pkg::SPEED_W-1:0]  in_measured_speed,
  input  logic                                 in_vehicle_valid,
  input  logic                                 in_path_valid,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pidc_pkg::THR_W-1:0]    out_throttle,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  pidc_pkg::cfg_t     cfg;
  pidc_pkg::dp_cmd_t  cmd;
  pidc_pkg::dp_stat_t stat;

  pidc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_flags_ok (in_vehicle_valid & in_path_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  pidc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .stat              (stat),
    .in_now_time       (in_now_time),
    .in_target_speed   (in_target_speed),
    .in_measured_speed (in_measured_speed),
    .out_throttle      (out_throttle)
  );

endmodule
